>>> src/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants of the ChaCha20 stream XOR block: the state
// constants, register indexes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cc20_pkg;

  // Number of column+diagonal double rounds per keystream block.
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_CNT_W   = $clog2(DOUBLE_ROUNDS);

  // Sixteen 32-bit words of block state.
  localparam int NUM_WORDS = 16;
  localparam int WORD_W    = 32;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // The four fixed words that open the block state.
  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_PAIR_ZERO  = 3'd0,
    REG_KEY_PAIR_ONE   = 3'd1,
    REG_KEY_PAIR_TWO   = 3'd2,
    REG_KEY_PAIR_THREE = 3'd3,
    REG_NONCE_LOW      = 3'd4,
    REG_NONCE_HIGH     = 3'd5,
    REG_START_COUNT    = 3'd6
  } reg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;  // a request is taken this cycle
    logic       load;    // copy the input state into the working state
    logic       arx;     // run one add-xor-rotate step on all four lanes
    logic [1:0] step;    // which of the four quarter-round steps
    logic       diag;    // diagonal half of a double round
    logic       finish;  // add the input state and store the keystream
    logic       emit;    // write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_block;  // next byte starts a fresh keystream block
    logic out_free;    // result register can take a new result
  } stat_t;

  // Rotate a word left by a constant amount.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_W-1 -: WORD_W];
  endfunction

endpackage

>>> src/cc20_in_if.sv
// ----------------------------------------------------------------------------
// cc20_in_if
// Input channel: one message byte and its end-of-message mark per request.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       final_byte;

  modport source (output valid, output plain_byte, output final_byte, input ready);
  modport sink   (input valid, input plain_byte, input final_byte, output ready);
endinterface

>>> src/cc20_out_if.sv
// ----------------------------------------------------------------------------
// cc20_out_if
// Output channel: one enciphered byte and its end-of-message mark per request.
// ----------------------------------------------------------------------------
interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       final_out;

  modport source (output valid, output cipher_byte, output final_out, input ready);
  modport sink   (input valid, input cipher_byte, input final_out, output ready);
endinterface

>>> src/cc20_ctrl.sv
// ----------------------------------------------------------------------------
// cc20_ctrl
// Controller: takes requests, sequences the round steps of a keystream block
// and hands each result to the datapath's result register.
// ----------------------------------------------------------------------------
module cc20_ctrl
  import cc20_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t                 state, state_next;
  logic [1:0]             step, step_next;
  logic                   diag, diag_next;
  logic [ROUND_CNT_W-1:0] dround, dround_next;

  // State and round counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      diag   <= 1'b0;
      dround <= '0;
    end else begin
      state  <= state_next;
      step   <= step_next;
      diag   <= diag_next;
      dround <= dround_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    step_next   = step;
    diag_next   = diag;
    dround_next = dround;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.step    = step;
    cmd.diag    = diag;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.need_block ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: begin
        cmd.load    = 1'b1;
        step_next   = '0;
        diag_next   = 1'b0;
        dround_next = '0;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.arx   = 1'b1;
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          diag_next = ~diag;
          if (diag) begin
            if (dround == ROUND_CNT_W'(DOUBLE_ROUNDS - 1)) begin
              dround_next = '0;
              state_next  = ST_FINISH;
            end else begin
              dround_next = dround + ROUND_CNT_W'(1);
            end
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/cc20_dpath.sv
// ----------------------------------------------------------------------------
// cc20_dpath
// Datapath: configuration registers, the working state with its four-lane
// add-xor-rotate unit, the keystream store, message position and counter,
// and the result register.
// ----------------------------------------------------------------------------
module cc20_dpath
  import cc20_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            plain_byte,
  input  logic                  final_byte,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  cc20_out_if.source            data_out
);

  // Configuration registers.
  logic [63:0] key_pair_zero, key_pair_one, key_pair_two, key_pair_three;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] start_count;

  // Message state.
  logic [5:0]  byte_position;
  logic [31:0] block_count;
  logic        message_active;

  // Held request and block state.
  logic [7:0]        hold_byte;
  logic              hold_final;
  logic [WORD_W-1:0] init_words [NUM_WORDS];
  logic [WORD_W-1:0] work       [NUM_WORDS];
  logic [WORD_W-1:0] work_next  [NUM_WORDS];
  logic [WORD_W-1:0] ks_words   [NUM_WORDS];

  // Result register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_final;
  logic [WORD_W-1:0] ks_word;
  logic [7:0]        ks_byte;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pair_zero  <= '0;
      key_pair_one   <= '0;
      key_pair_two   <= '0;
      key_pair_three <= '0;
      nonce_low      <= '0;
      nonce_high     <= '0;
      start_count    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY_PAIR_ZERO:  key_pair_zero  <= cfg_data;
        REG_KEY_PAIR_ONE:   key_pair_one   <= cfg_data;
        REG_KEY_PAIR_TWO:   key_pair_two   <= cfg_data;
        REG_KEY_PAIR_THREE: key_pair_three <= cfg_data;
        REG_NONCE_LOW:      nonce_low      <= cfg_data;
        REG_NONCE_HIGH:     nonce_high     <= cfg_data[31:0];
        REG_START_COUNT:    start_count    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Input state of the block built from the configuration and the counter.
  always_comb begin
    init_words[0]  = SIGMA_0;
    init_words[1]  = SIGMA_1;
    init_words[2]  = SIGMA_2;
    init_words[3]  = SIGMA_3;
    init_words[4]  = key_pair_zero[31:0];
    init_words[5]  = key_pair_zero[63:32];
    init_words[6]  = key_pair_one[31:0];
    init_words[7]  = key_pair_one[63:32];
    init_words[8]  = key_pair_two[31:0];
    init_words[9]  = key_pair_two[63:32];
    init_words[10] = key_pair_three[31:0];
    init_words[11] = key_pair_three[63:32];
    init_words[12] = block_count;
    init_words[13] = nonce_low[31:0];
    init_words[14] = nonce_low[63:32];
    init_words[15] = nonce_high;
  end

  // One quarter-round step on all four lanes. The diagonal half shifts
  // the b, c and d rows by one, two and three lanes.
  always_comb begin
    logic [1:0]        lane, ob, oc, od;
    logic [3:0]        ia, ib, ic, id;
    logic [WORD_W-1:0] sum;
    work_next = work;
    for (int j = 0; j < 4; j++) begin
      lane = 2'(j);
      ob   = lane + {1'b0, cmd.diag};
      oc   = lane + {cmd.diag, 1'b0};
      od   = lane + {cmd.diag, cmd.diag};
      ia   = {2'b00, lane};
      ib   = {2'b01, ob};
      ic   = {2'b10, oc};
      id   = {2'b11, od};
      unique case (cmd.step)
        2'd0: begin
          sum           = work[ia] + work[ib];
          work_next[ia] = sum;
          work_next[id] = rotl(work[id] ^ sum, 16);
        end
        2'd1: begin
          sum           = work[ic] + work[id];
          work_next[ic] = sum;
          work_next[ib] = rotl(work[ib] ^ sum, 12);
        end
        2'd2: begin
          sum           = work[ia] + work[ib];
          work_next[ia] = sum;
          work_next[id] = rotl(work[id] ^ sum, 8);
        end
        default: begin
          sum           = work[ic] + work[id];
          work_next[ic] = sum;
          work_next[ib] = rotl(work[ib] ^ sum, 7);
        end
      endcase
    end
  end

  // Working state and keystream store.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= init_words;
    end else if (cmd.arx) begin
      work <= work_next;
    end
    if (cmd.finish) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        ks_words[i] <= work[i] + init_words[i];
      end
    end
  end

  // Held request.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_byte  <= plain_byte;
      hold_final <= final_byte;
    end
  end

  // Message position, block counter and message flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      block_count    <= '0;
      message_active <= 1'b0;
    end else begin
      if (cmd.accept && !message_active) begin
        block_count    <= start_count;
        message_active <= 1'b1;
      end else if (cmd.finish) begin
        block_count <= block_count + 32'd1;
      end
      if (cmd.emit) begin
        if (hold_final) begin
          byte_position  <= '0;
          message_active <= 1'b0;
        end else begin
          byte_position <= byte_position + 6'd1;
        end
      end
    end
  end

  // Keystream byte for the current position, little-endian within a word.
  assign ks_word = ks_words[byte_position[5:2]];
  assign ks_byte = ks_word[{byte_position[1:0], 3'b000} +: 8];

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte  <= hold_byte ^ ks_byte;
      out_final <= hold_final;
    end
  end

  assign data_out.valid       = out_valid;
  assign data_out.cipher_byte = out_byte;
  assign data_out.final_out   = out_final;

  // Status to the controller.
  assign stat.need_block = (byte_position == 6'd0);
  assign stat.out_free   = !out_valid || data_out.ready;

endmodule

>>> src/chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 stream cipher, one message byte per request.
// ----------------------------------------------------------------------------
// Each byte is XORed with the next ChaCha20 keystream byte made from the
// configured key, nonce and block counter; a byte marked final ends the
// message, and the next message restarts its counter at start_count. A byte
// inside a 64-byte block is taken, then loaded into the result register
// once it is free. The byte that opens a block first loads the input state,
// runs the double rounds on the single add-xor-rotate unit, which runs one
// quarter-round step on four lanes per cycle, then adds the input state.
// Write configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module chacha20_stream_xor
  import cc20_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cc20_in_if.sink               data_in,
  cc20_out_if.source            data_out
);

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  cc20_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data_in.valid),
    .in_ready (data_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  cc20_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .plain_byte (data_in.plain_byte),
    .final_byte (data_in.final_byte),
    .cmd        (cmd),
    .stat       (stat),
    .data_out   (data_out)
  );

endmodule
